FILE: hw/rtl/rtex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtex_pkg
// Shared opcodes, constants and types for the register-type execute block.
// ----------------------------------------------------------------------------
package rtex_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RegCnt = 32;
  localparam int unsigned AddrW  = $clog2(RegCnt);
  localparam int unsigned OpW    = 4;
  localparam int unsigned ShW    = 5;

  localparam logic [OpW-1:0] OP_PRESET = 4'd0;
  localparam logic [OpW-1:0] OP_ADD    = 4'd1;
  localparam logic [OpW-1:0] OP_ADDU   = 4'd2;
  localparam logic [OpW-1:0] OP_SUB    = 4'd3;
  localparam logic [OpW-1:0] OP_AND    = 4'd4;
  localparam logic [OpW-1:0] OP_OR     = 4'd5;
  localparam logic [OpW-1:0] OP_XOR    = 4'd6;
  localparam logic [OpW-1:0] OP_NOR    = 4'd7;
  localparam logic [OpW-1:0] OP_NAND   = 4'd8;
  localparam logic [OpW-1:0] OP_SLT    = 4'd9;
  localparam logic [OpW-1:0] OP_SLL    = 4'd10;
  localparam logic [OpW-1:0] OP_SRL    = 4'd11;
  localparam logic [OpW-1:0] OP_SRA    = 4'd12;
  localparam logic [OpW-1:0] OP_JR     = 4'd13;

  localparam logic [31:0] U32_1 = 32'd1;
  localparam logic [31:0] U32_0 = 32'd0;

  // execute-stage outcome
  typedef struct packed {
    logic [31:0] result;
    logic        zero_err;
    logic        ovf;
    logic        jump;
    logic        wr_en;
  } exe_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rtex_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtex_regfile
// Register file: synchronous memory with registered reads, per-entry valid
// bits for the zero reset image, and bypass of the write in flight.
// ----------------------------------------------------------------------------
module rtex_regfile #(
  parameter int unsigned DataW  = rtex_pkg::DataW,
  parameter int unsigned RegCnt = rtex_pkg::RegCnt,
  parameter int unsigned AddrW  = $clog2(RegCnt)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rs_addr,
  input  wire logic [AddrW-1:0] rt_addr,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [DataW-1:0] wr_data,
  output logic      [DataW-1:0] a_data,
  output logic      [DataW-1:0] b_data
);

  logic [DataW-1:0] mem [RegCnt];
  logic [RegCnt-1:0] vld;

  logic [DataW-1:0] mem_a_q;
  logic [DataW-1:0] mem_b_q;
  logic             vld_a;
  logic             vld_b;
  logic             fwd_a;
  logic             fwd_b;
  logic [DataW-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_a_q <= mem[rs_addr];
      mem_b_q <= mem[rt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // the write committing at the read edge is not yet in the array
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_a    <= vld[rs_addr];
      vld_b    <= vld[rt_addr];
      fwd_a    <= wr_en && (wr_addr == rs_addr);
      fwd_b    <= wr_en && (wr_addr == rt_addr);
      fwd_data <= wr_data;
    end
  end

  assign a_data = fwd_a ? fwd_data : (vld_a ? mem_a_q : '0);
  assign b_data = fwd_b ? fwd_data : (vld_b ? mem_b_q : '0);

endmodule
`default_nettype wire

FILE: hw/rtl/rtex_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtex_alu
// Execute logic: arithmetic, logic, compare, shifts, jump and preset.
// ----------------------------------------------------------------------------
module rtex_alu (
  input  wire logic [rtex_pkg::OpW-1:0]   opcode,
  input  wire logic [rtex_pkg::AddrW-1:0] rd_index,
  input  wire logic [rtex_pkg::ShW-1:0]   shift_amount,
  input  wire logic [31:0]                preset_value,
  input  wire logic [31:0]                a,
  input  wire logic [31:0]                b,
  output rtex_pkg::exe_res_t              res
);

  logic [31:0] sum;
  logic [31:0] diff;
  logic        alu_op;

  assign sum  = a + b;
  assign diff = a - b;

  always_comb begin
    res          = '0;
    res.result   = rtex_pkg::U32_0;
    alu_op       = 1'b1;
    case (opcode)
      rtex_pkg::OP_PRESET: begin
        res.result = preset_value;
        res.wr_en  = 1'b1;
        alu_op     = 1'b0;
      end
      rtex_pkg::OP_ADD: begin
        res.result = sum;
        res.ovf    = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
      end
      rtex_pkg::OP_ADDU: res.result = sum;
      rtex_pkg::OP_SUB: begin
        res.result = diff;
        res.ovf    = (a[31] ^ b[31]) & (a[31] ^ diff[31]);
      end
      rtex_pkg::OP_AND:  res.result = a & b;
      rtex_pkg::OP_OR:   res.result = a | b;
      rtex_pkg::OP_XOR:  res.result = a ^ b;
      rtex_pkg::OP_NOR:  res.result = ~(a | b);
      rtex_pkg::OP_NAND: res.result = ~(a & b);
      rtex_pkg::OP_SLT:
        res.result = ($signed(a) < $signed(b)) ? rtex_pkg::U32_1 : rtex_pkg::U32_0;
      rtex_pkg::OP_SLL: res.result = b << shift_amount;
      rtex_pkg::OP_SRL: res.result = b >> shift_amount;
      rtex_pkg::OP_SRA: res.result = 32'($signed(b) >>> shift_amount);
      rtex_pkg::OP_JR: begin
        res.result = a;
        res.jump   = 1'b1;
        alu_op     = 1'b0;
      end
      default: alu_op = 1'b0;
    endcase
    // ALU writes to register zero are dropped and flagged
    if (alu_op) begin
      if (rd_index == '0) begin
        res.zero_err = 1'b1;
      end else begin
        res.wr_en = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/r_type_execute_with_register_file.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r_type_execute_with_register_file
// Register-type execute unit over a 32 x 32 register file.
// ----------------------------------------------------------------------------
// Pipeline: the regfile read is registered, then execute and write back into
//   the output register.
// Throughput: one request per cycle while the result side is not stalled; the
//   registered memory read and the one-deep write bypass set this.
// Reset: rst clears pipeline valids and the register valid bits, so every
//   register reads as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
module r_type_execute_with_register_file (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rtex_pkg::OpW-1:0]     opcode,
  input  wire logic [rtex_pkg::AddrW-1:0]   rs_num,
  input  wire logic [rtex_pkg::AddrW-1:0]   rt_num,
  input  wire logic [rtex_pkg::AddrW-1:0]   rd_index,
  input  wire logic [rtex_pkg::ShW-1:0]     shift_amount,
  input  wire logic [31:0]                  preset_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [31:0]                       result_value,
  output logic                              write_zero_error,
  output logic                              overflow_flag,
  output logic                              jump_taken
);

  logic                       s1_valid;
  logic [rtex_pkg::OpW-1:0]   s1_op;
  logic [rtex_pkg::AddrW-1:0] s1_rd;
  logic [rtex_pkg::ShW-1:0]   s1_sh;
  logic [31:0]                s1_pv;
  logic                       s1_adv;
  logic                       accept;
  logic [31:0]                a_data;
  logic [31:0]                b_data;
  rtex_pkg::exe_res_t         exe;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  rtex_regfile #(
    .DataW (rtex_pkg::DataW),
    .RegCnt(rtex_pkg::RegCnt),
    .AddrW (rtex_pkg::AddrW)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rs_addr(rs_num),
    .rt_addr(rt_num),
    .wr_en  (s1_adv && exe.wr_en),
    .wr_addr(s1_rd),
    .wr_data(exe.result),
    .a_data (a_data),
    .b_data (b_data)
  );

  rtex_alu u_alu (
    .opcode      (s1_op),
    .rd_index    (s1_rd),
    .shift_amount(s1_sh),
    .preset_value(s1_pv),
    .a           (a_data),
    .b           (b_data),
    .res         (exe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= opcode;
      s1_rd <= rd_index;
      s1_sh <= shift_amount;
      s1_pv <= preset_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_value     <= exe.result;
      write_zero_error <= exe.zero_err;
      overflow_flag    <= exe.ovf;
      jump_taken       <= exe.jump;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rtex_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtex_checker
// Port-level checks for the execute block, bound to the top level.
// ----------------------------------------------------------------------------
module rtex_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result_value,
  input wire logic        write_zero_error,
  input wire logic        overflow_flag,
  input wire logic        jump_taken
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(jump_taken) && $stable(write_zero_error))
    else $error("stalled result changed");

  // an accepted request is followed by a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after request");

  a_jump_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && jump_taken |-> !write_zero_error && !overflow_flag)
    else $error("jump result carries ALU flags");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind r_type_execute_with_register_file rtex_checker u_rtex_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result_value    (result_value),
  .write_zero_error(write_zero_error),
  .overflow_flag   (overflow_flag),
  .jump_taken      (jump_taken)
);
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the register-type execute unit and its register file.
// Requests go in over a valid/ready channel with random idle gaps. A shadow
// register file predicts every result in order, and the checker compares each
// returned result field by field. Random stalls on the result side cover
// backpressure.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic [rtex_pkg::OpW-1:0] opcode_t;
  typedef logic [rtex_pkg::ShW-1:0] shamt_t;
  typedef logic [4:0]               reg_num_t;

  // opcodes the block treats as no-ops
  localparam opcode_t OP_NOP_A = 4'd14;
  localparam opcode_t OP_NOP_B = 4'd15;

  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 8;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [31:0] value;
    logic        zero_err;
    logic        ovf;
    logic        jump;
  } instr_result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  opcode_t           opcode       = '0;
  reg_num_t          rs_num       = '0;
  reg_num_t          rt_num       = '0;
  reg_num_t          rd_index     = '0;
  shamt_t            shift_amount = '0;
  logic [31:0]       preset_value = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [31:0]       result_value;
  logic              write_zero_error;
  logic              overflow_flag;
  logic              jump_taken;

  logic [31:0]       shadow_regs [rtex_pkg::RegCnt];
  instr_result_t     pending_results[$];
  int                n_issued   = 0;
  int                n_retired  = 0;
  int                n_errors   = 0;
  int                idle_cycles = 0;
  int                rx_hold    = 0;
  bit                tx_quiet   = 1'b0;
  bit                rx_quiet   = 1'b0;

  r_type_execute_with_register_file dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .rs_num           (rs_num),
    .rt_num           (rt_num),
    .rd_index         (rd_index),
    .shift_amount     (shift_amount),
    .preset_value     (preset_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_value     (result_value),
    .write_zero_error (write_zero_error),
    .overflow_flag    (overflow_flag),
    .jump_taken       (jump_taken)
  );

  always #2 clk = ~clk;

  // Executes one instruction on the shadow register file.
  function automatic instr_result_t exec_instr(input opcode_t op,
                                               input reg_num_t rs, rt, rd,
                                               input shamt_t sh,
                                               input logic [31:0] pv);
    instr_result_t r;
    logic [31:0]   a;
    logic [31:0]   b;
    logic          alu;
    a   = shadow_regs[rs];
    b   = shadow_regs[rt];
    r   = '0;
    alu = 1'b1;
    case (op)
      rtex_pkg::OP_PRESET: begin
        shadow_regs[rd] = pv;
        r.value = pv;
        alu = 1'b0;
      end
      rtex_pkg::OP_ADD: begin
        r.value = a + b;
        r.ovf = ~(a[31] ^ b[31]) & (a[31] ^ r.value[31]);
      end
      rtex_pkg::OP_ADDU: r.value = a + b;
      rtex_pkg::OP_SUB: begin
        r.value = a - b;
        r.ovf = (a[31] ^ b[31]) & (a[31] ^ r.value[31]);
      end
      rtex_pkg::OP_AND:  r.value = a & b;
      rtex_pkg::OP_OR:   r.value = a | b;
      rtex_pkg::OP_XOR:  r.value = a ^ b;
      rtex_pkg::OP_NOR:  r.value = ~(a | b);
      rtex_pkg::OP_NAND: r.value = ~(a & b);
      rtex_pkg::OP_SLT:
        r.value = ($signed(a) < $signed(b)) ? rtex_pkg::U32_1 : rtex_pkg::U32_0;
      rtex_pkg::OP_SLL:  r.value = b << sh;
      rtex_pkg::OP_SRL:  r.value = b >> sh;
      rtex_pkg::OP_SRA:  r.value = $signed(b) >>> sh;
      rtex_pkg::OP_JR: begin
        r.value = a;
        r.jump = 1'b1;
        alu = 1'b0;
      end
      default: alu = 1'b0;
    endcase
    if (alu) begin
      if (rd == 5'd0) r.zero_err = 1'b1;
      else shadow_regs[rd] = r.value;
    end
    return r;
  endfunction

  // Sends one request; returns on the edge where it is accepted, valid left high.
  task automatic issue_instr(input opcode_t op, input reg_num_t rs, rt, rd,
                             input shamt_t sh, input logic [31:0] pv);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    rs_num       <= rs;
    rt_num       <= rt;
    rd_index     <= rd;
    shift_amount <= sh;
    preset_value <= pv;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(exec_instr(op, rs, rt, rd, sh, pv));
    n_issued++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_preset_extremes();
    issue_instr(rtex_pkg::OP_PRESET, 5'd0, 5'd0, 5'd1, 5'd0, 32'h7FFF_FFFF);
    issue_instr(rtex_pkg::OP_PRESET, 5'd0, 5'd0, 5'd2, 5'd0, 32'h0000_0001);
    issue_instr(rtex_pkg::OP_PRESET, 5'd0, 5'd0, 5'd3, 5'd0, 32'h8000_0000);
    issue_instr(rtex_pkg::OP_PRESET, 5'd0, 5'd0, 5'd4, 5'd0, 32'hFFFF_FFFF);
    // preset may load register zero
    issue_instr(rtex_pkg::OP_PRESET, 5'd31, 5'd31, 5'd0, 5'd31, 32'hFFFF_FFFF);
    issue_instr(rtex_pkg::OP_JR, 5'd0, 5'd0, 5'd0, 5'd0, 32'h0);
  endtask

  task automatic test_arith_overflow();
    issue_instr(rtex_pkg::OP_ADD,  5'd1, 5'd2, 5'd5, 5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_SUB,  5'd3, 5'd2, 5'd6, 5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_ADDU, 5'd1, 5'd2, 5'd7, 5'd0, 32'h0);
    // ALU write to r0 is dropped and flagged
    issue_instr(rtex_pkg::OP_ADD,  5'd1, 5'd2, 5'd0, 5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_SUB,  5'd2, 5'd4, 5'd8, 5'd0, 32'h0);
  endtask

  task automatic test_logic_ops();
    issue_instr(rtex_pkg::OP_AND,  5'd1, 5'd4, 5'd9,  5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_OR,   5'd3, 5'd2, 5'd9,  5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_XOR,  5'd1, 5'd4, 5'd9,  5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_NOR,  5'd3, 5'd2, 5'd9,  5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_NAND, 5'd4, 5'd4, 5'd9,  5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_SLT,  5'd3, 5'd2, 5'd10, 5'd0, 32'h0);
    issue_instr(rtex_pkg::OP_SLT,  5'd2, 5'd3, 5'd11, 5'd0, 32'h0);
  endtask

  task automatic test_shifts();
    issue_instr(rtex_pkg::OP_SLL, 5'd0, 5'd4, 5'd12, 5'd31, 32'h0);
    issue_instr(rtex_pkg::OP_SRL, 5'd0, 5'd4, 5'd13, 5'd31, 32'h0);
    issue_instr(rtex_pkg::OP_SRA, 5'd0, 5'd3, 5'd14, 5'd31, 32'h0);
    issue_instr(rtex_pkg::OP_SRA, 5'd0, 5'd3, 5'd15, 5'd0,  32'h0);
    issue_instr(rtex_pkg::OP_SRL, 5'd0, 5'd1, 5'd16, 5'd0,  32'h0);
  endtask

  task automatic test_jump_and_unused();
    issue_instr(rtex_pkg::OP_JR, 5'd5,  5'd0,  5'd0,  5'd0,  32'h0);
    issue_instr(OP_NOP_A,        5'd1,  5'd2,  5'd17, 5'd3,  32'hFFFF_FFFF);
    issue_instr(OP_NOP_B,        5'd31, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
  endtask

  // Mostly real instructions over values seeded by presets; a few no-ops.
  task automatic test_random_traffic(input int count);
    opcode_t op;
    int      pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)      op = rtex_pkg::OP_PRESET;
      else if (pick < 97) op = opcode_t'($urandom_range(rtex_pkg::OP_ADD, rtex_pkg::OP_JR));
      else                op = $urandom_range(0, 1) ? OP_NOP_A : OP_NOP_B;
      issue_instr(op, reg_num_t'($urandom_range(0, 31)), reg_num_t'($urandom_range(0, 31)),
                  reg_num_t'($urandom_range(0, 31)), shamt_t'($urandom_range(0, 31)),
                  pick_value());
    end
  endtask

  task automatic test_random_streaming(input int count);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_traffic(count);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Result side: random stalls and in-order compare.
  always @(posedge clk) begin
    int            stall;
    instr_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, result_value);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value) begin
          $display("%0t: result_value: expected %h, actual %h", $time, want.value,
                   result_value);
          n_errors++;
        end
        if (write_zero_error !== want.zero_err) begin
          $display("%0t: write_zero_error: expected %b, actual %b", $time, want.zero_err,
                   write_zero_error);
          n_errors++;
        end
        if (overflow_flag !== want.ovf) begin
          $display("%0t: overflow_flag: expected %b, actual %b", $time, want.ovf,
                   overflow_flag);
          n_errors++;
        end
        if (jump_taken !== want.jump) begin
          $display("%0t: jump_taken: expected %b, actual %b", $time, want.jump,
                   jump_taken);
          n_errors++;
        end
      end
      n_retired++;
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        rx_hold   <= stall;
      end
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any request or result moving.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // register file comes out of reset all zero
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_preset_extremes();
    test_arith_overflow();
    test_logic_ops();
    test_shifts();
    test_jump_and_unused();
    test_random_traffic(RANDOM_ITEMS / 3);
    // hold off until the pipe is empty, then restart traffic
    wait_drained();
    test_random_streaming(RANDOM_ITEMS / 3);
    wait_drained();
    test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d instructions: directed corners, random traffic with idle gaps",
             n_issued);
    $display("and stalls, and a back-to-back stretch; %0d results compared", n_retired);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
